@@ hw/rtl/path_traversal_detector_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the path traversal detector
// Shared helpers for the concurrent checks bound to the top level.
// ----------------------------------------------------------------------------
`ifndef PATH_TRAVERSAL_DETECTOR_DEFINES_SVH
`define PATH_TRAVERSAL_DETECTOR_DEFINES_SVH

// Clocked check, quiet while reset is held.
`define PTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define PTD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hw/rtl/ptd_pkg.sv @@
// ----------------------------------------------------------------------------
// ptd_pkg
// Types, rule patterns and helpers shared by the path traversal detector.
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam int unsigned RuleCount = 9;
  localparam int unsigned HistDepth = 9;
  localparam int unsigned WinLen    = HistDepth + 1;
  localparam int unsigned RuleW     = 4;
  localparam int unsigned PatBits   = 8 * WinLen;

  localparam logic [RuleW-1:0] RuleNone = 4'd0;
  localparam logic [RuleW-1:0] RuleMax  = 4'd9;

  typedef logic [PatBits-1:0]      pat_t;
  typedef logic [RuleCount-1:0]    mask_t;
  typedef logic [HistDepth-1:0][7:0] hist_t;
  typedef logic [WinLen-1:0][7:0]  win_t;

  typedef struct packed {
    logic [7:0] path_byte;
    logic       no_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic             attack;
    logic [RuleW-1:0] rule_hit;
  } out_t;

  // Patterns right-justified: last character in bits [7:0].
  localparam pat_t PatText [RuleCount] = '{
    pat_t'("../"),
    pat_t'("..\\"),
    pat_t'(".env"),
    pat_t'("id_rsa"),
    pat_t'({"id_ed", "25519"}),
    pat_t'("shadow"),
    pat_t'("passwd"),
    pat_t'("sam"),
    pat_t'("system")
  };

  localparam int unsigned PatLen [RuleCount] = '{3, 3, 4, 6, 10, 6, 6, 3, 6};

  localparam logic PatFold [RuleCount] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1,
                                           1'b1, 1'b1, 1'b1, 1'b1};

  // ASCII A-Z to a-z, everything else unchanged.
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/ptd_matcher.sv @@
// ----------------------------------------------------------------------------
// ptd_matcher
// Parallel compare of all rule patterns ending at the current byte.
// ----------------------------------------------------------------------------
module ptd_matcher (
  input  ptd_pkg::win_t  win_i,   // element 0 is the current byte
  output ptd_pkg::mask_t hits_o
);
  import ptd_pkg::*;

  always_comb begin
    logic [7:0] c;
    logic       ok;
    hits_o = '0;
    for (int r = 0; r < RuleCount; r++) begin
      ok = 1'b1;
      for (int d = 0; d < WinLen; d++) begin
        c = PatFold[r] ? fold_case(win_i[d]) : win_i[d];
        if (d < PatLen[r] && c != PatText[r][8*d +: 8]) begin
          ok = 1'b0;
        end
      end
      hits_o[r] = ok;
    end
  end

endmodule

@@ hw/rtl/ptd_report.sv @@
// ----------------------------------------------------------------------------
// ptd_report
// Builds the end-of-path result: any-hit flag and first rule in check order.
// ----------------------------------------------------------------------------
module ptd_report (
  input  ptd_pkg::mask_t mask_i,
  output ptd_pkg::out_t  res_o
);
  import ptd_pkg::*;

  always_comb begin
    res_o.attack   = |mask_i;
    res_o.rule_hit = RuleNone;
    // walk downward so the lowest set rule wins
    for (int r = RuleCount - 1; r >= 0; r--) begin
      if (mask_i[r]) begin
        res_o.rule_hit = RuleW'(r + 1);
      end
    end
  end

endmodule

@@ hw/rtl/path_traversal_detector.sv @@
// ----------------------------------------------------------------------------
// path_traversal_detector
// Streams path bytes, flags traversal sequences and sensitive file names.
// ----------------------------------------------------------------------------
//   channel | direction | payload          | result
//   in      | sink      | ptd_pkg::in_t    | one byte (or none) per item
//   out     | source    | ptd_pkg::out_t   | one item per path, on last
//
// One item per cycle sustained unless a last item waits on out; a byte is
// matched in the cycle after it is taken, from the single register stage
// in front of the pattern compare. A path result is registered into out_item_q.
// Reset clears the valid flags, the byte history and the hit mask.
// A stalled out only holds back last items; other items keep flowing.
module path_traversal_detector (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ptd_pkg::in_t   in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ptd_pkg::out_t  out_item_o
);
  import ptd_pkg::*;

  logic  in_valid_q, in_valid_d;
  in_t   item_q;
  hist_t hist_q, hist_d;
  mask_t mask_q, mask_d, mask_upd;
  mask_t hits;
  logic  out_valid_q, out_valid_d;
  out_t  out_item_q, res;
  logic  out_free, advance;

  ptd_matcher u_matcher (
    .win_i  ({hist_q, item_q.path_byte}),
    .hits_o (hits)
  );

  ptd_report u_report (
    .mask_i (mask_upd),
    .res_o  (res)
  );

  always_comb begin
    out_free   = ~out_valid_q | out_ready_i;
    advance    = in_valid_q & (~item_q.last | out_free);
    in_ready_o = ~in_valid_q | advance;
    mask_upd   = item_q.no_byte ? mask_q : (mask_q | hits);

    in_valid_d = in_ready_o ? in_valid_i : in_valid_q;

    hist_d = hist_q;
    mask_d = mask_q;
    if (advance) begin
      if (item_q.last) begin
        hist_d = '0;
        mask_d = '0;
      end else if (!item_q.no_byte) begin
        hist_d = {hist_q[HistDepth-2:0], item_q.path_byte};
        mask_d = mask_upd;
      end
    end

    out_valid_d = out_valid_q;
    if (advance && item_q.last) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hist_q      <= '0;
      mask_q      <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      hist_q      <= hist_d;
      mask_q      <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      item_q <= in_item_i;
    end
    if (advance && item_q.last) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ hw/rtl/ptd_checker.sv @@
// ----------------------------------------------------------------------------
// ptd_checker
// Port-level checks on the result channel of the path traversal detector.
// ----------------------------------------------------------------------------
`include "path_traversal_detector_defines.svh"

module ptd_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input ptd_pkg::out_t out_item_o
);
  import ptd_pkg::*;

  logic stall;
  logic code_set;

  assign stall    = out_valid_o && !out_ready_i;
  assign code_set = (out_item_o.rule_hit != RuleNone);

  // a stalled result keeps its payload
  `PTD_ASSERT(a_out_hold, stall |=> out_valid_o && $stable(out_item_o), "stalled result changed")

  // attack flag and rule code agree
  `PTD_ASSERT(a_attack_code, out_valid_o |-> (out_item_o.attack == code_set), "attack/code differ")

  // rule code within the defined set
  `PTD_ASSERT(a_code_range, out_valid_o |-> (out_item_o.rule_hit <= RuleMax), "rule code out of range")

  // no result while reset is held and was also held at the previous sample
  `PTD_ASSERT_ALWAYS(a_reset_quiet, !rst_ni && $past(!rst_ni) |-> !out_valid_o, "valid in reset")

endmodule

bind path_traversal_detector ptd_checker u_ptd_checker (.*);
